/* rtl/voxel_bev_scatter_accumulate_unit_assert.svh */
// assertion macros for the voxel pooling unit
`ifndef VOXEL_BEV_SCATTER_ACCUMULATE_UNIT_ASSERT_SVH
`define VOXEL_BEV_SCATTER_ACCUMULATE_UNIT_ASSERT_SVH

// checked while out of reset
`define VBSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define VBSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/vbsa_pkg.sv */
// shared types and constants of the voxel pooling unit
`timescale 1ns / 1ps
package vbsa_pkg;
    localparam int DEF_MAX_BATCH    = 2;
    localparam int DEF_MAX_GRID_X   = 64;
    localparam int DEF_MAX_GRID_Y   = 64;
    localparam int DEF_MAX_CHANNELS = 64;

    localparam int CELL_W = 40;
    localparam int PROD_W = 33;
    localparam int CFG_W  = 11;
    localparam int IN_W   = 72;

    localparam logic [1:0] OP_ACC  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_RCLR = 2'd2;

    localparam logic [1:0] CFG_GRID_X   = 2'd0;
    localparam logic [1:0] CFG_GRID_Y   = 2'd1;
    localparam logic [1:0] CFG_GRID_Z   = 2'd2;
    localparam logic [1:0] CFG_CHANNELS = 2'd3;

    typedef enum logic [1:0] {
        K_ACC,
        K_READ,
        K_RCLR
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  dropped;
    } t_cls;

    localparam int CLS_W = $bits(t_cls);
endpackage

/* rtl/voxel_bev_scatter_accumulate_unit.sv */
// top level of the voxel pooling unit
// Accepts items on the s_axis channel: tuser carries op (accumulate, read,
// read and clear), tdata the batch, voxel coordinates, channel, depth weight
// and context value. One result per item leaves on m_axis: tdata is the cell
// value, tuser the dropped and saturated flags. Config writes go through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must make them only while the
// unit is idle, since the unit itself does not enforce this. The front
// registers classification, grid address and the weight times context product,
// then queues the item in a two-entry queue. The back does the read-modify-write
// on the single-port grid memory through the steps pop, memory read, and update
// and write with the result register for an item in range; a dropped item is
// loaded into the result register at its pop. Throughput is set by the back's
// read-then-write sequence on the memory port. After reset the back runs a
// clearing pass over all MAX_BATCH*MAX_GRID_Y*MAX_GRID_X*MAX_CHANNELS cells
// (524288 by default); s_axis_tready stays low meanwhile.
// When m_axis_tready is low the result is held, the queue fills and then
// s_axis_tready drops; no item is lost.
`timescale 1ns / 1ps
module voxel_bev_scatter_accumulate_unit import vbsa_pkg::*; #(
    parameter int MAX_BATCH    = DEF_MAX_BATCH,
    parameter int MAX_GRID_X   = DEF_MAX_GRID_X,
    parameter int MAX_GRID_Y   = DEF_MAX_GRID_Y,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // batch_index, voxel_x, voxel_y, voxel_z, channel, depth_weight, context_value
    input  logic [IN_W-1:0]   s_axis_tdata,
    // op
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // cell_value
    output logic [CELL_W-1:0] m_axis_tdata,
    // dropped, saturated
    output logic [1:0]        m_axis_tuser
);
    localparam int CELLS = MAX_BATCH * MAX_GRID_Y * MAX_GRID_X * MAX_CHANNELS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QW    = CLS_W + AW + PROD_W;

    logic clear_done, f_valid, q_full, q_empty, q_pop, push;
    t_cls f_cls, q_cls;
    logic [AW-1:0] f_addr, q_addr;
    logic signed [PROD_W-1:0] f_prod, q_prod;
    logic [QW-1:0] q_out;

    vbsa_front #(
        .MAX_BATCH(MAX_BATCH), .MAX_GRID_X(MAX_GRID_X),
        .MAX_GRID_Y(MAX_GRID_Y), .MAX_CHANNELS(MAX_CHANNELS), .AW(AW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_enable(clear_done),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_data(s_axis_tdata),
        .o_valid(f_valid), .i_full(q_full),
        .o_cls(f_cls), .o_addr(f_addr), .o_prod(f_prod)
    );

    assign push = f_valid && !q_full;

    vbsa_fifo #(.W(QW)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data({f_cls, f_addr, f_prod}), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_out)
    );

    assign {q_cls, q_addr, q_prod} = q_out;

    vbsa_back #(.CELLS(CELLS), .AW(AW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .o_clear_done(clear_done),
        .i_empty(q_empty), .o_pop(q_pop),
        .i_cls(q_cls), .i_addr(q_addr), .i_prod(q_prod),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_cell(m_axis_tdata), .o_dropped(m_axis_tuser[0]),
        .o_saturated(m_axis_tuser[1])
    );
endmodule

/* rtl/vbsa_front.sv */
// front stage: config registers, range check, address and product
`timescale 1ns / 1ps
module vbsa_front import vbsa_pkg::*; #(
    parameter int MAX_BATCH    = DEF_MAX_BATCH,
    parameter int MAX_GRID_X   = DEF_MAX_GRID_X,
    parameter int MAX_GRID_Y   = DEF_MAX_GRID_Y,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int AW           = 19
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_enable,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_op,
    input  logic [IN_W-1:0]          i_data,
    output logic                     o_valid,
    input  logic                     i_full,
    output t_cls                     o_cls,
    output logic [AW-1:0]            o_addr,
    output logic signed [PROD_W-1:0] o_prod
);
    logic [6:0]  r_gx, r_gy, r_ch;
    logic [10:0] r_gz;
    logic        r_valid;
    t_cls        r_cls;
    logic [AW-1:0] r_addr;
    logic signed [PROD_W-1:0] r_prod;

    logic              b;
    logic signed [10:0] x, y, z;
    logic [5:0]        c;
    logic [15:0]       w;
    logic signed [15:0] ctx;
    logic [10:0]       lim_x, lim_y, lim_c;
    logic              ok, take;
    t_cls              n_cls;
    logic [AW-1:0]     a_by, a_byx, n_addr;
    logic signed [PROD_W-1:0] n_prod;

    assign b   = i_data[0];
    assign x   = i_data[11:1];
    assign y   = i_data[22:12];
    assign z   = i_data[33:23];
    assign c   = i_data[39:34];
    assign w   = i_data[55:40];
    assign ctx = i_data[71:56];

    assign lim_x = ({4'd0, r_gx} < 11'(MAX_GRID_X)) ? {4'd0, r_gx} : 11'(MAX_GRID_X);
    assign lim_y = ({4'd0, r_gy} < 11'(MAX_GRID_Y)) ? {4'd0, r_gy} : 11'(MAX_GRID_Y);
    assign lim_c = ({4'd0, r_ch} < 11'(MAX_CHANNELS)) ? {4'd0, r_ch} : 11'(MAX_CHANNELS);

    always_comb begin
        ok = ({4'd0, b} < 5'(MAX_BATCH))
             && !x[10] && (11'(x) < lim_x)
             && !y[10] && (11'(y) < lim_y)
             && ({5'd0, c} < lim_c);
        unique case (i_op)
            OP_ACC: begin
                n_cls.kind = K_ACC;
                ok = ok && !z[10] && (11'(z) < r_gz);
            end
            OP_RCLR: n_cls.kind = K_RCLR;
            default: n_cls.kind = K_READ;
        endcase
        n_cls.dropped = !ok;
    end

    assign a_by   = AW'(b) * AW'(MAX_GRID_Y) + AW'(y[9:0]);
    assign a_byx  = a_by * AW'(MAX_GRID_X) + AW'(x[9:0]);
    assign n_addr = a_byx * AW'(MAX_CHANNELS) + AW'(c);
    assign n_prod = $signed({1'b0, w}) * ctx;

    assign o_ready = i_enable && (!r_valid || !i_full);
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx    <= 7'd64;
            r_gy    <= 7'd64;
            r_gz    <= 11'd1;
            r_ch    <= 7'd64;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_X:   r_gx <= i_cfg_data[6:0];
                    CFG_GRID_Y:   r_gy <= i_cfg_data[6:0];
                    CFG_GRID_Z:   r_gz <= i_cfg_data;
                    CFG_CHANNELS: r_ch <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (!i_full) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls  <= n_cls;
            r_addr <= n_addr;
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign o_addr  = r_addr;
    assign o_prod  = r_prod;
endmodule

/* rtl/vbsa_fifo.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps
module vbsa_fifo import vbsa_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

/* rtl/vbsa_back.sv */
// back stage: grid memory, clearing pass, read-modify-write, result register
`timescale 1ns / 1ps
module vbsa_back import vbsa_pkg::*; #(
    parameter int CELLS = 524288,
    parameter int AW    = 19
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    output logic                     o_clear_done,
    input  logic                     i_empty,
    output logic                     o_pop,
    input  t_cls                     i_cls,
    input  logic [AW-1:0]            i_addr,
    input  logic signed [PROD_W-1:0] i_prod,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [CELL_W-1:0]        o_cell,
    output logic                     o_dropped,
    output logic                     o_saturated
);
    typedef enum logic [1:0] {S_CLR, S_IDLE, S_READ, S_EXEC} t_state;

    logic [CELL_W-1:0] r_mem [CELLS];
    t_state            r_state;
    logic [AW-1:0]     r_clr, r_addr;
    t_kind             r_kind;
    logic signed [PROD_W-1:0] r_prod;
    logic [CELL_W-1:0] r_rd;
    logic              r_valid, r_drop, r_sat;
    logic [CELL_W-1:0] r_cell;

    logic              slot_free, we, set_valid;
    logic [AW-1:0]     wa;
    logic [CELL_W-1:0] wd, n_cell;
    logic signed [CELL_W:0] sum;
    logic              n_sat;

    assign slot_free = !r_valid || i_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty && slot_free;
    assign set_valid = (o_pop && i_cls.dropped) || (r_state == S_EXEC);

    always_comb begin
        sum   = $signed({r_rd[CELL_W-1], r_rd}) + (CELL_W+1)'(r_prod);
        n_sat = 1'b0;
        if (r_kind == K_ACC) begin
            if (sum[CELL_W] != sum[CELL_W-1]) begin
                n_sat  = 1'b1;
                n_cell = sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}}
                                     : {1'b0, {(CELL_W-1){1'b1}}};
            end else begin
                n_cell = sum[CELL_W-1:0];
            end
        end else begin
            n_cell = r_rd;
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = '0;
        if (r_state == S_CLR) begin
            we = 1'b1;
            wa = r_clr;
        end else if (r_state == S_EXEC) begin
            we = (r_kind != K_READ);
            wd = (r_kind == K_ACC) ? n_cell : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (set_valid) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(CELLS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cls.dropped) begin
                            r_cell  <= '0;
                            r_drop  <= 1'b1;
                            r_sat   <= 1'b0;
                        end else begin
                            r_addr  <= i_addr;
                            r_kind  <= i_cls.kind;
                            r_prod  <= i_prod;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_cell  <= n_cell;
                    r_drop  <= 1'b0;
                    r_sat   <= n_sat;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clear_done = (r_state != S_CLR);
    assign o_valid      = r_valid;
    assign o_cell       = r_cell;
    assign o_dropped    = r_drop;
    assign o_saturated  = r_sat;
endmodule

/* rtl/vbsa_checker.sv */
// port-level checks of the voxel pooling unit and their bind
`timescale 1ns / 1ps
`include "voxel_bev_scatter_accumulate_unit_assert.svh"
module vbsa_checker import vbsa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [CELL_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser
);
    `VBSA_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !s_axis_tready && !m_axis_tvalid, "unit not quiet after reset")
    `VBSA_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `VBSA_ASSERT(a_drop, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1], "dropped item with value or saturation")
    `VBSA_ASSERT(a_sat, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == {1'b1, {(CELL_W-1){1'b0}}} || m_axis_tdata == {1'b0, {(CELL_W-1){1'b1}}}, "saturated value not at a limit")
endmodule

bind voxel_bev_scatter_accumulate_unit vbsa_checker u_vbsa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

/* bench/voxel_bev_scatter_accumulate_unit_test.sv */
// testbench for the voxel pooling unit: random and directed items checked against a cell model
`timescale 1ns / 1ps
module voxel_bev_scatter_accumulate_unit_test;
    import vbsa_pkg::*;

    typedef struct {
        logic [CELL_W-1:0] value;
        logic              dropped;
        logic              saturated;
    } cell_result_t;

    class cell_scoreboard;
        longint       grid[int unsigned];
        int           size_x, size_y, size_z, chans;
        cell_result_t expected_q[$];
        int           errors;

        function void clear_all();
            grid.delete();
            size_x = 64;
            size_y = 64;
            size_z = 1;
            chans = 64;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int v);
            case (idx)
                CFG_GRID_X: size_x = v & 'h7f;
                CFG_GRID_Y: size_y = v & 'h7f;
                CFG_GRID_Z: size_z = v & 'h7ff;
                CFG_CHANNELS: chans = v & 'h7f;
            endcase
        endfunction

        function void note(logic [1:0] op, logic b, logic signed [10:0] x, logic signed [10:0] y,
                           logic signed [10:0] z, logic [5:0] c, logic [15:0] w,
                           logic signed [15:0] ctx);
            int           lx, ly, lc;
            bit           ok;
            longint       cur_val, sum;
            int unsigned  key;
            cell_result_t r;
            lx = size_x < DEF_MAX_GRID_X ? size_x : DEF_MAX_GRID_X;
            ly = size_y < DEF_MAX_GRID_Y ? size_y : DEF_MAX_GRID_Y;
            lc = chans < DEF_MAX_CHANNELS ? chans : DEF_MAX_CHANNELS;
            r.value = '0;
            r.dropped = 1'b0;
            r.saturated = 1'b0;
            ok = int'(b) < DEF_MAX_BATCH && int'(x) >= 0 && int'(x) < lx
                 && int'(y) >= 0 && int'(y) < ly && int'(c) < lc;
            if (op == OP_ACC) ok = ok && int'(z) >= 0 && int'(z) < size_z;
            if (!ok) begin
                r.dropped = 1'b1;
            end else begin
                key = ((int'(b) * DEF_MAX_GRID_Y + int'(y)) * DEF_MAX_GRID_X + int'(x))
                      * DEF_MAX_CHANNELS + int'(c);
                cur_val = grid.exists(key) ? grid[key] : 0;
                if (op == OP_ACC) begin
                    sum = cur_val + longint'(w) * longint'(ctx);
                    if (sum > (64'sd1 <<< 39) - 1) begin
                        sum = (64'sd1 <<< 39) - 1;
                        r.saturated = 1'b1;
                    end else if (sum < -(64'sd1 <<< 39)) begin
                        sum = -(64'sd1 <<< 39);
                        r.saturated = 1'b1;
                    end
                    grid[key] = sum;
                    cur_val = sum;
                end else if (op == OP_RCLR) begin
                    grid[key] = 0;
                end
                r.value = cur_val[CELL_W-1:0];
            end
            expected_q.push_back(r);
        endfunction

        function void check(logic [CELL_W-1:0] value, logic [1:0] flags);
            cell_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result value=%h flags=%b", value, flags);
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value || flags[0] !== e.dropped || flags[1] !== e.saturated) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value=%h dropped=%b sat=%b, got value=%h dropped=%b sat=%b",
                             e.value, e.dropped, e.saturated, value, flags[0], flags[1]);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CELL_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    cell_scoreboard cells;
    int             send_idle;
    int             recv_stall;
    int             dir_x, dir_y, dir_z, dir_c;

    voxel_bev_scatter_accumulate_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) cells.check(m_axis_tdata, m_axis_tuser);
    end

    // called just after a rising edge, returns just after the accepting edge
    task send_item(logic [1:0] op, logic b, logic [10:0] x, logic [10:0] y, logic [10:0] z,
                   logic [5:0] c, logic [15:0] w, logic [15:0] ctx);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {ctx, w, c, z, y, x, b};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        cells.note(op, b, x, y, z, c, w, ctx);
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (cells.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, int v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v[CFG_W-1:0];
        @(posedge i_clk);
        cells.set_reg(idx, v);
    endtask

    task set_grid(int gx, int gy, int gz, int ch);
        write_reg(CFG_GRID_X, gx);
        write_reg(CFG_GRID_Y, gy);
        write_reg(CFG_GRID_Z, gz);
        write_reg(CFG_CHANNELS, ch);
        i_cfg_we <= 1'b0;
    endtask

    function logic [10:0] pick_coord(int lim);
        int r;
        r = $urandom_range(99);
        if (lim <= 0) lim = 1;
        if (r < 84) return 11'($urandom_range(lim - 1));
        if (r < 90) return 11'(lim + $urandom_range(1));
        if (r < 94) return 11'h7ff;
        return 11'($urandom);
    endfunction

    function logic [15:0] pick_val();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h7fff;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task random_items(int n, bit sat_run);
        int          r, lx, ly, lc;
        logic [1:0]  op;
        logic [15:0] w, ctx;
        for (int i = 0; i < n; i++) begin
            lx = cells.size_x < 64 ? cells.size_x : 64;
            ly = cells.size_y < 64 ? cells.size_y : 64;
            lc = cells.chans < 64 ? cells.chans : 64;
            r = $urandom_range(99);
            if (sat_run) begin
                op = (i == n / 2) ? OP_RCLR : (r < 95 ? OP_ACC : OP_READ);
                w = 16'hffff - 16'($urandom_range(15));
                ctx = (i < n / 2) ? 16'h7fff - 16'($urandom_range(15))
                                  : 16'h8000 + 16'($urandom_range(15));
                send_item(op, 1'b0, '0, '0, '0, '0, w, ctx);
            end else begin
                op = r < 70 ? OP_ACC : r < 82 ? OP_READ : r < 94 ? OP_RCLR : 2'd3;
                send_item(op, 1'($urandom), pick_coord(lx), pick_coord(ly),
                          pick_coord(cells.size_z > 1024 ? 1024 : cells.size_z),
                          6'($urandom_range(99) < 90 ? $urandom_range(lc > 0 ? lc - 1 : 0)
                                                     : $urandom),
                          pick_val(), pick_val());
            end
        end
    endtask

    initial begin
        cells = new();
        cells.clear_all();
        send_idle = 0;
        recv_stall = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every op, drops on the x, y and z bounds
        send_item(OP_ACC, 0, 0, 0, 0, 0, 16'hffff, 16'h7fff);
        send_item(OP_ACC, 0, 0, 0, 0, 0, 16'hffff, 16'h8000);
        send_item(OP_ACC, 0, 0, 0, 0, 0, 16'h0000, 16'h7fff);
        send_item(OP_ACC, 0, 0, 0, 0, 0, 16'h1234, 16'h0100);
        send_item(OP_READ, 0, 0, 0, 11'h7ff, 0, 0, 0);
        send_item(2'd3, 0, 0, 0, 11'h400, 0, 16'hffff, 16'hffff);
        send_item(OP_RCLR, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_ACC, 1, 63, 63, 0, 63, 16'hffff, 16'h8000);
        send_item(OP_RCLR, 1, 63, 63, 5, 63, 0, 0);
        send_item(OP_ACC, 0, 64, 0, 0, 0, 16'hffff, 16'h7fff);
        send_item(OP_ACC, 0, 11'h7ff, 0, 0, 0, 16'hffff, 16'h7fff);
        send_item(OP_ACC, 0, 0, 11'h400, 0, 0, 16'hffff, 16'h7fff);
        send_item(OP_READ, 0, 0, 64, 0, 0, 0, 0);
        send_item(OP_ACC, 0, 0, 0, 1, 0, 16'hffff, 16'h7fff);
        send_item(OP_ACC, 0, 0, 0, 11'h7ff, 0, 16'hffff, 16'h7fff);
        send_item(OP_ACC, 0, 11'h3ff, 11'h3ff, 11'h3ff, 63, 16'h5555, 16'haaaa);
        send_item(OP_ACC, 1, 11'h2aa, 11'h555, 11'h2aa, 42, 16'haaaa, 16'h5555);
        send_item(OP_READ, 1, 5, 7, 0, 3, 0, 0);
        wait_drained();

        random_items(200, 0);
        wait_drained();

        set_grid(1, 1, 1, 1);
        send_idle = 56;
        random_items(560, 1);
        wait_drained();

        set_grid(64, 64, 1024, 64);
        send_idle = 0;
        recv_stall = 56;
        random_items(250, 0);
        wait_drained();

        set_grid(127, 5, 2047, 0);
        send_idle = 17;
        recv_stall = 17;
        random_items(80, 0);
        wait_drained();

        set_grid(3, 2, 7, 5);
        random_items(250, 0);
        wait_drained();

        set_grid(64, 127, 0, 127);
        send_idle = 56;
        recv_stall = 0;
        random_items(120, 0);
        wait_drained();

        set_grid(8, 8, 16, 4);
        send_idle = 0;
        random_items(190, 0);
        wait_drained();

        if (cells.errors == 0 && cells.expected_q.size() == 0) begin
            $display("** voxel_bev_scatter_accumulate_unit: PASSED **");
        end else begin
            $display("** voxel_bev_scatter_accumulate_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("** voxel_bev_scatter_accumulate_unit: FAILED **");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/vbsa_pkg.sv
rtl/vbsa_front.sv
rtl/vbsa_fifo.sv
rtl/vbsa_back.sv
rtl/voxel_bev_scatter_accumulate_unit.sv
rtl/vbsa_checker.sv
bench/voxel_bev_scatter_accumulate_unit_test.sv
